// ----- design/iibs_pkg.sv -----
package iibs_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_WINDOW = 64;
    localparam int PIXEL_BITS = 16;

    // Field widths of the ports
    localparam int PIX_FIELD_BITS = 16;
    localparam int IMG_W_BITS     = 11;
    localparam int WIN_CFG_BITS   = 7;
    localparam int BOX_BITS       = 28;
    localparam int POS_BITS       = 10;
    localparam int ROW_BITS       = 10;
    localparam int ROWSUM_BITS    = 26;
    localparam int SUM_BITS       = 36;

    // Line store geometry
    localparam int RING_ROWS   = MAX_WINDOW + 1;
    localparam int STORE_DEPTH = RING_ROWS * MAX_WIDTH;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int COL_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RING_BITS   = $clog2(RING_ROWS);
    localparam int WIN_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int WID_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int RT_BITS     = ((RING_BITS > WIN_BITS) ? RING_BITS : WIN_BITS) + 1;
    localparam int CMP_BASE    = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
    localparam int CMP_BITS    = ((CMP_BASE > WIN_BITS) ? CMP_BASE : WIN_BITS) + 1;

    localparam logic [PIX_FIELD_BITS-1:0] PIX_MASK =
        PIX_FIELD_BITS'((64'd1 << PIXEL_BITS) - 64'd1);
    localparam logic [ROW_BITS-1:0] ROW_LAST = '1;

    // Configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 11;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_SIZE = 1'd1;
    localparam logic [IMG_W_BITS-1:0]   IMAGE_WIDTH_RESET = 11'd1024;
    localparam logic [WIN_CFG_BITS-1:0] WINDOW_SIZE_RESET = 7'd3;

    // Result queue
    localparam int OUTQ_DEPTH    = 4;
    localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);
    localparam int CREDIT_BITS   = OUTQ_CNT_BITS + 1;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [SUM_BITS-1:0]  sum_t;

    typedef struct packed {
        logic [BOX_BITS-1:0] box_sum;
        logic [POS_BITS-1:0] top_row;
        logic [POS_BITS-1:0] left_col;
    } box_t;

    // Per-item request from the scan counters to the accumulator
    typedef struct packed {
        logic                   emit;
        logic                   above_zero;
        logic                   top_zero;
        logic                   left_zero;
        logic [ROWSUM_BITS-1:0] row_sum;
        logic [POS_BITS-1:0]    top_row;
        logic [POS_BITS-1:0]    left_col;
        addr_t                  wr_addr;
        addr_t                  rd_above;
        addr_t                  rd_top;
        addr_t                  rd_top_left;
        addr_t                  rd_left;
    } req_t;

    typedef struct packed {
        logic s1_emit;
        logic s2_busy;
    } stage_stat_t;

    function automatic addr_t make_addr(input logic [RING_BITS-1:0] ring,
                                        input logic [COL_BITS-1:0]  col);
        return ADDR_BITS'(ring) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(col);
    endfunction

endpackage

// ----- design/iibs_if.sv -----
interface iibs_pix_if import iibs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [PIX_FIELD_BITS-1:0] pixel;
    logic                      frame_start;

    modport source (output valid, pixel, frame_start, input ready);
    modport sink (input valid, pixel, frame_start, output ready);
endinterface

interface iibs_box_if import iibs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BOX_BITS-1:0] box_sum;
    logic [POS_BITS-1:0] top_row;
    logic [POS_BITS-1:0] left_col;

    modport source (output valid, box_sum, top_row, left_col, input ready);
    modport sink (input valid, box_sum, top_row, left_col, output ready);
endinterface

// ----- design/iibs_ram.sv -----
module iibs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 36,
    parameter int ABITS = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [ABITS-1:0] wa,
    input  logic [WIDTH-1:0] wd,
    input  logic             re,
    input  logic [ABITS-1:0] ra0,
    input  logic [ABITS-1:0] ra1,
    output logic [WIDTH-1:0] rq0,
    output logic [WIDTH-1:0] rq1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    // Read-during-write returns the old entry
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rq0 <= mem[ra0];
            rq1 <= mem[ra1];
        end
    end

endmodule

// ----- design/iibs_scan.sv -----
module iibs_scan import iibs_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [PIX_FIELD_BITS-1:0] pixel,
    input  logic                      frame_start,
    input  logic [IMG_W_BITS-1:0]     image_width,
    input  logic [WIN_CFG_BITS-1:0]   window_size,
    output req_t                      req
);

    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic [RING_BITS-1:0]   ring_reg, ring_next;
    logic [ROWSUM_BITS-1:0] rs_reg, rs_next;

    logic [WID_BITS-1:0]  width;
    logic [WIN_BITS-1:0]  win;
    logic [ROW_BITS-1:0]  row0, r;
    logic [COL_BITS-1:0]  col0, c, col_left;
    logic [RING_BITS-1:0] ring0, ring, ring_prev, ring_top;
    logic                 wrap, last;
    logic [CMP_BITS-1:0]  r1, c1, w_ext, top1, left1;
    logic [RT_BITS-1:0]   ring_diff;

    function automatic logic [RING_BITS-1:0] ring_after(input logic [ROW_BITS-1:0]  row,
                                                        input logic [RING_BITS-1:0] rg);
        logic [RING_BITS-1:0] res;
        if (row == ROW_LAST || rg == RING_BITS'(RING_ROWS - 1))
        begin
            res = '0;
        end
        else
        begin
            res = rg + RING_BITS'(1);
        end
        return res;
    endfunction

    always_comb
    begin
        if (image_width == '0)
        begin
            width = WID_BITS'(1);
        end
        else if (int'(image_width) > MAX_WIDTH)
        begin
            width = WID_BITS'(MAX_WIDTH);
        end
        else
        begin
            width = WID_BITS'(image_width);
        end

        if (window_size == '0)
        begin
            win = WIN_BITS'(1);
        end
        else if (int'(window_size) > MAX_WINDOW)
        begin
            win = WIN_BITS'(MAX_WINDOW);
        end
        else
        begin
            win = WIN_BITS'(window_size);
        end
    end

    // Position of this item: frame start first, then end a row cut short
    always_comb
    begin
        row0  = frame_start ? '0 : row_reg;
        col0  = frame_start ? '0 : col_reg;
        ring0 = frame_start ? '0 : ring_reg;
        wrap  = WID_BITS'(col0) >= width;
        r     = wrap ? row0 + ROW_BITS'(1) : row0;
        ring  = wrap ? ring_after(row0, ring0) : ring0;
        c     = wrap ? '0 : col0;

        r1    = CMP_BITS'(r) + CMP_BITS'(1);
        c1    = CMP_BITS'(c) + CMP_BITS'(1);
        w_ext = CMP_BITS'(win);
        top1  = r1 - w_ext;
        left1 = c1 - w_ext;
        col_left = COL_BITS'(left1 - CMP_BITS'(1));

        ring_prev = (ring == '0) ? RING_BITS'(RING_ROWS - 1) : ring - RING_BITS'(1);
        ring_diff = RT_BITS'(ring) - RT_BITS'(win);
        if (ring_diff[RT_BITS-1])
        begin
            ring_top = RING_BITS'(ring_diff + RT_BITS'(RING_ROWS));
        end
        else
        begin
            ring_top = RING_BITS'(ring_diff);
        end

        last = (WID_BITS'(c) + WID_BITS'(1)) >= width;
        rs_next = ((c == '0) ? '0 : rs_reg) + ROWSUM_BITS'(pixel & PIX_MASK);
        row_next  = last ? r + ROW_BITS'(1) : r;
        ring_next = last ? ring_after(r, ring) : ring;
        col_next  = last ? '0 : c + COL_BITS'(1);

        req.emit        = (r1 >= w_ext) && (c1 >= w_ext);
        req.above_zero  = (r == '0);
        req.top_zero    = (top1 == '0);
        req.left_zero   = (left1 == '0);
        req.row_sum     = rs_next;
        req.top_row     = POS_BITS'(top1);
        req.left_col    = POS_BITS'(left1);
        req.wr_addr     = make_addr(ring, c);
        req.rd_above    = make_addr(ring_prev, c);
        req.rd_top      = make_addr(ring_top, c);
        req.rd_top_left = make_addr(ring_top, col_left);
        req.rd_left     = make_addr(ring, col_left);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            ring_reg <= '0;
            rs_reg   <= '0;
        end
        else if (accept)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            ring_reg <= ring_next;
            rs_reg   <= rs_next;
        end
    end

    ring_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ring_reg <= RING_BITS'(RING_ROWS - 1))
        else $error("ring row pointer out of range");

endmodule

// ----- design/iibs_accum.sv -----
module iibs_accum import iibs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  req_t        req,
    input  sum_t        q_above,
    input  sum_t        q_top,
    input  sum_t        q_top_left,
    input  sum_t        q_left,
    output logic        mem_we,
    output addr_t       mem_wa,
    output sum_t        mem_wd,
    output logic        push,
    output box_t        push_data,
    output stage_stat_t stat
);

    // Stage 1: store data arrives
    logic                   s1_valid_reg;
    logic                   s1_emit_reg;
    logic                   s1_above_zero_reg, s1_top_zero_reg, s1_left_zero_reg;
    logic [ROWSUM_BITS-1:0] s1_rs_reg;
    logic [POS_BITS-1:0]    s1_top_row_reg, s1_left_col_reg;
    addr_t                  s1_wr_addr_reg;
    logic [3:0]             s1_hit_reg;
    sum_t                   s1_fwd_reg;

    // Stage 2: final add
    logic                s2_valid_reg;
    logic [BOX_BITS-1:0] s2_cur_reg, s2_diag_reg, s2_left_reg;
    logic [POS_BITS-1:0] s2_top_row_reg, s2_left_col_reg;

    sum_t                above, top, top_left, left, cur;
    logic [BOX_BITS-1:0] diag;

    always_comb
    begin
        above    = s1_hit_reg[0] ? s1_fwd_reg : q_above;
        top      = s1_hit_reg[1] ? s1_fwd_reg : q_top;
        top_left = s1_hit_reg[2] ? s1_fwd_reg : q_top_left;
        left     = s1_hit_reg[3] ? s1_fwd_reg : q_left;
        if (s1_above_zero_reg)
        begin
            above = '0;
        end
        if (s1_top_zero_reg)
        begin
            top      = '0;
            top_left = '0;
        end
        if (s1_left_zero_reg)
        begin
            left     = '0;
            top_left = '0;
        end
        cur  = SUM_BITS'(s1_rs_reg) + above;
        diag = BOX_BITS'(top_left) - BOX_BITS'(top);
    end

    assign mem_we = s1_valid_reg;
    assign mem_wa = s1_wr_addr_reg;
    assign mem_wd = cur;

    // Catch the entry that stage 1 writes at the same edge as the new reads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg       <= req.emit;
            s1_above_zero_reg <= req.above_zero;
            s1_top_zero_reg   <= req.top_zero;
            s1_left_zero_reg  <= req.left_zero;
            s1_rs_reg         <= req.row_sum;
            s1_top_row_reg    <= req.top_row;
            s1_left_col_reg   <= req.left_col;
            s1_wr_addr_reg    <= req.wr_addr;
            s1_fwd_reg        <= cur;
            s1_hit_reg[0]     <= s1_valid_reg && (req.rd_above == s1_wr_addr_reg);
            s1_hit_reg[1]     <= s1_valid_reg && (req.rd_top == s1_wr_addr_reg);
            s1_hit_reg[2]     <= s1_valid_reg && (req.rd_top_left == s1_wr_addr_reg);
            s1_hit_reg[3]     <= s1_valid_reg && (req.rd_left == s1_wr_addr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        s2_cur_reg      <= BOX_BITS'(cur);
        s2_diag_reg     <= diag;
        s2_left_reg     <= BOX_BITS'(left);
        s2_top_row_reg  <= s1_top_row_reg;
        s2_left_col_reg <= s1_left_col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    assign push               = s2_valid_reg;
    assign push_data.box_sum  = s2_cur_reg - s2_left_reg + s2_diag_reg;
    assign push_data.top_row  = s2_top_row_reg;
    assign push_data.left_col = s2_left_col_reg;
    assign stat.s1_emit       = s1_valid_reg && s1_emit_reg;
    assign stat.s2_busy       = s2_valid_reg;

    s2_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg && s1_emit_reg))
        else $error("final stage loaded without a result in stage 1");

endmodule

// ----- design/iibs_outq.sv -----
module iibs_outq import iibs_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  box_t                     push_data,
    output logic [OUTQ_CNT_BITS-1:0] count,
    iibs_box_if.source               sums
);

    box_t                     entries [OUTQ_DEPTH];
    logic [OUTQ_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUTQ_CNT_BITS-1:0] count_reg;
    logic                     pop;

    assign pop           = sums.valid && sums.ready;
    assign sums.valid    = (count_reg != '0);
    assign sums.box_sum  = entries[rd_ptr_reg].box_sum;
    assign sums.top_row  = entries[rd_ptr_reg].top_row;
    assign sums.left_col = entries[rd_ptr_reg].left_col;
    assign count         = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == OUTQ_PTR_BITS'(OUTQ_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + OUTQ_PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == OUTQ_PTR_BITS'(OUTQ_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + OUTQ_PTR_BITS'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + OUTQ_CNT_BITS'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - OUTQ_CNT_BITS'(1);
            end
        end
    end

    no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && count_reg == OUTQ_CNT_BITS'(OUTQ_DEPTH)))
        else $error("result queue overflow");

endmodule

// ----- design/integral_image_box_sum_unit.sv -----
// Streaming integral-image box sum. Pixels enter in row-major order, one per clock when the
// result side keeps up; frame_start marks row 0, column 0. For every pixel that closes a full
// window_size square the block offers the square's sum and its top-left corner on the result
// port once stage 1, stage 2 and the result queue have registered it; other pixels return
// nothing. The integral rows live in two identical copies of a 65-row by 1024-column line
// store (36-bit entries, one write and two registered reads each), so the four corner lookups
// and a store write go on together; that write port sets the rate of one pixel per clock.
// An entry written by the pixel just before is forwarded around the store. The store is
// not cleared at reset and needs no sweep: it is written before any sum reads it within a
// frame. A four-deep result queue takes up stalls on the result side; the input stalls only
// once the queue, with the results still in the pipeline counted, is full. Change image_width
// or window_size only between frames for sums that match a fresh frame.
module integral_image_box_sum_unit import iibs_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    iibs_pix_if.sink                 pixels,
    iibs_box_if.source               sums,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    logic [IMG_W_BITS-1:0]   image_width_reg;
    logic [WIN_CFG_BITS-1:0] window_size_reg;

    logic                     accept;
    req_t                     req;
    stage_stat_t              stat;
    logic                     mem_we, push;
    addr_t                    mem_wa;
    sum_t                     mem_wd;
    sum_t                     q_above, q_top, q_top_left, q_left;
    box_t                     push_data;
    logic [OUTQ_CNT_BITS-1:0] q_count;
    logic [CREDIT_BITS-1:0]   credit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= IMAGE_WIDTH_RESET;
            window_size_reg <= WINDOW_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH: image_width_reg <= IMG_W_BITS'(cfg_wdata);
                CFG_WINDOW_SIZE: window_size_reg <= WIN_CFG_BITS'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // Reserve a queue slot for every result still in the pipeline
    assign credit = CREDIT_BITS'(q_count) + CREDIT_BITS'(stat.s1_emit)
                  + CREDIT_BITS'(stat.s2_busy);
    assign pixels.ready = credit < CREDIT_BITS'(OUTQ_DEPTH);
    assign accept       = pixels.valid && pixels.ready;

    iibs_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel       (pixels.pixel),
        .frame_start (pixels.frame_start),
        .image_width (image_width_reg),
        .window_size (window_size_reg),
        .req         (req)
    );

    iibs_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (SUM_BITS),
        .ABITS (ADDR_BITS)
    ) u_store_col (
        .clk (clk),
        .we  (mem_we),
        .wa  (mem_wa),
        .wd  (mem_wd),
        .re  (accept),
        .ra0 (req.rd_above),
        .ra1 (req.rd_top),
        .rq0 (q_above),
        .rq1 (q_top)
    );

    iibs_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (SUM_BITS),
        .ABITS (ADDR_BITS)
    ) u_store_left (
        .clk (clk),
        .we  (mem_we),
        .wa  (mem_wa),
        .wd  (mem_wd),
        .re  (accept),
        .ra0 (req.rd_top_left),
        .ra1 (req.rd_left),
        .rq0 (q_top_left),
        .rq1 (q_left)
    );

    iibs_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req        (req),
        .q_above    (q_above),
        .q_top      (q_top),
        .q_top_left (q_top_left),
        .q_left     (q_left),
        .mem_we     (mem_we),
        .mem_wa     (mem_wa),
        .mem_wd     (mem_wd),
        .push       (push),
        .push_data  (push_data),
        .stat       (stat)
    );

    iibs_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .count     (q_count),
        .sums      (sums)
    );

    credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit <= CREDIT_BITS'(OUTQ_DEPTH))
        else $error("more results in flight than queue slots");

endmodule
